### rtl/ohs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohs_pkg
// Shared types, codes and sizes for the open-addressing hash set.
// ----------------------------------------------------------------------------
package ohs_pkg;

   localparam int SLOTS  = 1024;
   localparam int IDX_W  = $clog2(SLOTS);
   localparam int CAP_W  = IDX_W + 1;
   localparam int KEY_W  = 32;
   localparam int HASH_W = 32;

   // Remainder unit: bits of the hash retired per cycle
   localparam int MOD_BITS   = 4;
   localparam int MOD_STEPS  = HASH_W / MOD_BITS;
   localparam int MOD_CNT_W  = $clog2(MOD_STEPS);

   // Command codes
   localparam logic [1:0] CMD_FIND   = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;

   // Status codes
   localparam logic [1:0] ST_PRESENT = 2'd0;
   localparam logic [1:0] ST_FREE    = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;

   // Slot marks
   localparam logic [1:0] KIND_EMPTY    = 2'd0;
   localparam logic [1:0] KIND_TOMB     = 2'd1;
   localparam logic [1:0] KIND_OCCUPIED = 2'd2;

   typedef struct packed {
      logic [1:0]        command;
      logic [KEY_W-1:0]  key;
      logic [HASH_W-1:0] hash;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [IDX_W-1:0] slot;
      logic [1:0]       slot_kind;
   } rsp_type;

   typedef struct packed {
      logic [1:0]       mark;
      logic [KEY_W-1:0] key;
   } row_type;

   // Controller to datapath
   typedef struct packed {
      logic clear_wr;
      logic load_req;
      logic mod_step;
      logic probe_start;
      logic probe;
      logic commit;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_last;
      logic mod_last;
      logic probe_stop;
   } dp_sts_type;

endpackage

### rtl/ohs_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohs_mod
// Restoring remainder unit: hash modulo capacity, a few bits per cycle.
// ----------------------------------------------------------------------------
module ohs_mod (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        step,
   input  logic [ohs_pkg::HASH_W-1:0]  dividend,
   input  logic [ohs_pkg::CAP_W-1:0]   divisor,
   output logic [ohs_pkg::IDX_W-1:0]   remainder,
   output logic                        last
);
   import ohs_pkg::*;

   logic [HASH_W-1:0]    num_ff, num_in;
   logic [IDX_W-1:0]     rem_ff, rem_in;
   logic [MOD_CNT_W-1:0] cnt_ff;

   // Partial remainder stays below the divisor, so one compare and subtract
   // per bit is enough.
   always_comb begin
      logic [CAP_W-1:0] t;
      logic [IDX_W-1:0] r;
      logic [HASH_W-1:0] sh;
      r  = rem_ff;
      sh = num_ff;
      for (int i = 0; i < MOD_BITS; i++) begin
         t  = {r, sh[HASH_W-1]};
         sh = {sh[HASH_W-2:0], 1'b0};
         if (t >= divisor) begin
            t = t - divisor;
         end
         r = t[IDX_W-1:0];
      end
      rem_in = r;
      num_in = sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= '0;
      end else if (step) begin
         cnt_ff <= cnt_ff + MOD_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend;
         rem_ff <= '0;
      end else if (step) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
      end
   end

   assign remainder = rem_ff;
   assign last      = (cnt_ff == MOD_CNT_W'(MOD_STEPS - 1));

endmodule

### rtl/ohs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohs_datapath
// Slot store, capacity register, probe walker and result registers.
// ----------------------------------------------------------------------------
module ohs_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [ohs_pkg::CAP_W-1:0]   csr_wdata,
   input  ohs_pkg::req_type            req_data,
   input  ohs_pkg::ctrl_cmd_type       cmd,
   output ohs_pkg::dp_sts_type         sts,
   output ohs_pkg::rsp_type            rsp_data
);
   import ohs_pkg::*;

   logic [CAP_W-1:0] capacity_ff;
   logic [CAP_W-1:0] cap;

   logic [1:0]       command_ff;
   logic [KEY_W-1:0] key_ff;

   row_type          mem [SLOTS];
   row_type          rd_row_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             mem_we;
   logic [IDX_W-1:0] mem_wa;
   row_type          mem_wd;

   logic [IDX_W-1:0] clr_idx_ff;

   logic [IDX_W-1:0] mod_rem;
   logic             mod_last;

   logic [IDX_W-1:0] idx_ff, step_ff, tomb_idx_ff;
   logic             have_tomb_ff;
   logic [CAP_W-1:0] idx_plus, step_plus;
   logic [IDX_W-1:0] idx_nxt;

   logic             is_empty, is_tomb, is_match, last_step, any_tomb, stop;
   logic [IDX_W-1:0] first_tomb;
   logic [1:0]       st_in, kind_in;
   logic [IDX_W-1:0] slot_in;

   logic [1:0]       res_status_ff, res_kind_ff;
   logic [IDX_W-1:0] res_slot_ff;
   logic             wr_update;
   rsp_type          rsp_data_ff;

   // Capacity register; zero behaves as one, large values saturate
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_W'(SLOTS);
      end else if (csr_we) begin
         capacity_ff <= csr_wdata;
      end
   end

   always_comb begin
      if (capacity_ff == '0) begin
         cap = CAP_W'(1);
      end else if (capacity_ff > CAP_W'(SLOTS)) begin
         cap = CAP_W'(SLOTS);
      end else begin
         cap = capacity_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         command_ff <= req_data.command;
         key_ff     <= req_data.key;
      end
   end

   ohs_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.load_req),
      .step      (cmd.mod_step),
      .dividend  (req_data.hash),
      .divisor   (cap),
      .remainder (mod_rem),
      .last      (mod_last)
   );

   // Clearing pass after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff <= '0;
      end else if (cmd.clear_wr) begin
         clr_idx_ff <= clr_idx_ff + IDX_W'(1);
      end
   end

   // Next probe index with wrap at capacity
   assign idx_plus  = {1'b0, idx_ff} + CAP_W'(1);
   assign idx_nxt   = (idx_plus == cap) ? '0 : idx_plus[IDX_W-1:0];
   assign step_plus = {1'b0, step_ff} + CAP_W'(1);
   assign last_step = (step_plus == cap);

   // Read of the next slot is issued while the current one is checked
   assign rd_addr = cmd.probe_start ? mod_rem : idx_nxt;

   assign is_empty   = (rd_row_ff.mark == KIND_EMPTY);
   assign is_tomb    = (rd_row_ff.mark == KIND_TOMB);
   assign is_match   = !is_empty && !is_tomb && (rd_row_ff.key == key_ff);
   assign any_tomb   = have_tomb_ff || is_tomb;
   assign first_tomb = have_tomb_ff ? tomb_idx_ff : idx_ff;
   assign stop       = is_empty || is_match || last_step;

   always_comb begin
      if (is_match) begin
         st_in   = ST_PRESENT;
         slot_in = idx_ff;
         kind_in = KIND_OCCUPIED;
      end else if (any_tomb) begin
         st_in   = ST_FREE;
         slot_in = first_tomb;
         kind_in = KIND_TOMB;
      end else if (is_empty) begin
         st_in   = ST_FREE;
         slot_in = idx_ff;
         kind_in = KIND_EMPTY;
      end else begin
         st_in   = ST_FULL;
         slot_in = '0;
         kind_in = KIND_EMPTY;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.probe_start) begin
         idx_ff       <= mod_rem;
         step_ff      <= '0;
         have_tomb_ff <= 1'b0;
      end else if (cmd.probe) begin
         if (is_tomb && !have_tomb_ff) begin
            have_tomb_ff <= 1'b1;
            tomb_idx_ff  <= idx_ff;
         end
         if (stop) begin
            res_status_ff <= st_in;
            res_slot_ff   <= slot_in;
            res_kind_ff   <= kind_in;
         end else begin
            idx_ff  <= idx_nxt;
            step_ff <= step_plus[IDX_W-1:0];
         end
      end
   end

   // Store update at commit
   assign wr_update = ((command_ff == CMD_INSERT) && (res_status_ff == ST_FREE)) ||
                      ((command_ff == CMD_REMOVE) && (res_status_ff == ST_PRESENT));
   assign mem_we    = cmd.clear_wr || (cmd.commit && wr_update);
   assign mem_wa    = cmd.clear_wr ? clr_idx_ff : res_slot_ff;

   always_comb begin
      if (cmd.clear_wr) begin
         mem_wd.mark = KIND_EMPTY;
         mem_wd.key  = '0;
      end else begin
         mem_wd.mark = (command_ff == CMD_INSERT) ? KIND_OCCUPIED : KIND_TOMB;
         mem_wd.key  = key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_row_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_data_ff.status    <= res_status_ff;
         rsp_data_ff.slot      <= res_slot_ff;
         rsp_data_ff.slot_kind <= res_kind_ff;
      end
   end

   assign rsp_data       = rsp_data_ff;
   assign sts.clear_last = (clr_idx_ff == IDX_W'(SLOTS - 1));
   assign sts.mod_last   = mod_last;
   assign sts.probe_stop = stop;

   a_probe_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.probe |-> ({1'b0, idx_ff} < cap))
      else $error("probe index beyond capacity");

   a_rem_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.mod_step && mod_last) |=> ({1'b0, mod_rem} < cap))
      else $error("start slot not reduced below capacity");

   a_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && res_status_ff != ST_FULL) |-> ({1'b0, res_slot_ff} < cap))
      else $error("reported slot beyond capacity");

endmodule

### rtl/ohs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohs_ctrl
// Sequencer: clearing pass, remainder, probe walk, commit and output handshake.
// ----------------------------------------------------------------------------
module ohs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  ohs_pkg::dp_sts_type     sts,
   output ohs_pkg::ctrl_cmd_type   cmd
);
   import ohs_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_START,
      S_PROBE,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_HASH;
            end
         end
         S_HASH: begin
            cmd.mod_step = 1'b1;
            if (sts.mod_last) begin
               state_in = S_START;
            end
         end
         S_START: begin
            cmd.probe_start = 1'b1;
            state_in        = S_PROBE;
         end
         S_PROBE: begin
            cmd.probe = 1'b1;
            if (sts.probe_stop) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_no_req_while_clearing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_ready)
      else $error("request taken during clearing pass");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FINISH))
      else $error("response raised outside finish");

   a_finish_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && rsp_valid_ff && !rsp_ready) |=> (state_ff == S_FINISH))
      else $error("result committed over a pending response");

endmodule

### rtl/open_addressing_hash_set.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// open_addressing_hash_set
// Hash set with linear probing over a 1024-slot store.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries one transaction per lookup: command (find, insert, remove),
//    key and a hash computed upstream. rsp_* returns one transaction per
//    request: status, slot and the slot's prior kind.
//  - csr_we/csr_wdata set the capacity in use; write only while idle.
//  - After reset the store is swept to empty, one slot a cycle, across all
//    1024 slots; req_ready stays low until the sweep is done.
//  - An item probing n slots (1..capacity) passes through the remainder
//    unit (hash modulo capacity, four bits a cycle), a start state that
//    issues the first read, probing (one slot a cycle from the slot store's
//    read port) and a commit; a new item is taken only after the previous
//    one has committed.
//  - Items are handled one at a time. The result sits in an output register;
//    the next item is accepted and worked on while it waits, and only its
//    commit waits for rsp_ready.
// ----------------------------------------------------------------------------
module open_addressing_hash_set (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  ohs_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output ohs_pkg::rsp_type            rsp_data,
   input  logic                        csr_we,
   input  logic [ohs_pkg::CAP_W-1:0]   csr_wdata
);
   import ohs_pkg::*;

   ctrl_cmd_type cmd;
   dp_sts_type   sts;

   ohs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ohs_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

endmodule
